### sv/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the distance move controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package dpm_pkg;

	localparam int unsigned TIMEOUT_STEPS         = 120;
	localparam int unsigned ARRIVE_TOLERANCE      = 70;
	localparam int unsigned OBSTACLE_RANGE_TENTHS = 30;
	localparam int unsigned COUNTS_PER_CM         = 48;
	localparam int unsigned OBSTACLE_RANGE_MM     = OBSTACLE_RANGE_TENTHS * 10;

	localparam logic [15:0] BRAKE_DUTY = 16'd7999;
	localparam logic [15:0] OFFSET_A   = 16'd180;
	localparam logic [15:0] OFFSET_B   = 16'd83;
	localparam logic [15:0] OFFSET_C   = 16'd35;
	localparam logic [15:0] OFFSET_D   = 16'd39;

	// field widths
	localparam int unsigned DIST_W  = 11;
	localparam int unsigned SPEED_W = 2;
	localparam int unsigned ENC_W   = 16;
	localparam int unsigned RANGE_W = 16;
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 16;

	// item kinds
	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_INT_DIV     = 3'd1;
	localparam logic [CIDX_W-1:0] REG_KD_SLOW     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_KD_MEDIUM   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_KD_FAST     = 3'd4;
	localparam logic [CIDX_W-1:0] REG_LIM_SLOW    = 3'd5;
	localparam logic [CIDX_W-1:0] REG_LIM_MEDIUM  = 3'd6;
	localparam logic [CIDX_W-1:0] REG_LIM_FAST    = 3'd7;

	typedef enum logic [MODE_W-1:0] {
		MODE_DRIVE = 2'd0,
		MODE_COAST = 2'd1,
		MODE_BRAKE = 2'd2
	} bridge_mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_RUNNING  = 3'd0,
		STAT_REACHED  = 3'd1,
		STAT_OBSTACLE = 3'd2,
		STAT_TIMEOUT  = 3'd3,
		STAT_WAITING  = 3'd4,
		STAT_IDLE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WAIT = 3'b010,
		PH_RUN  = 3'b100
	} phase_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_EVAL = 8'b0000_0010,
		ST_MULP = 8'b0000_0100,
		ST_MULD = 8'b0000_1000,
		ST_DIVW = 8'b0001_0000,
		ST_SUM  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} seq_state_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              direction;
		bridge_mode_t      bridge_mode;
		status_t           status;
	} result_t;

endpackage

`default_nettype wire

### sv/dpm_if.sv
// ----------------------------------------------------------------------------
// dpm_item_if / dpm_result_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpm_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic signed [dpm_pkg::DIST_W-1:0]     move_distance;
	logic        [dpm_pkg::SPEED_W-1:0]    speed_class;
	logic        [dpm_pkg::ENC_W-1:0]      encoder_a;
	logic        [dpm_pkg::ENC_W-1:0]      encoder_b;
	logic        [dpm_pkg::ENC_W-1:0]      encoder_c;
	logic        [dpm_pkg::ENC_W-1:0]      encoder_d;
	logic        [dpm_pkg::RANGE_W-1:0]    range_reading;

	modport source (
		output valid, kind, move_distance, speed_class,
		output encoder_a, encoder_b, encoder_c, encoder_d, range_reading,
		input  ready
	);
	modport sink (
		input  valid, kind, move_distance, speed_class,
		input  encoder_a, encoder_b, encoder_c, encoder_d, range_reading,
		output ready
	);
endinterface

interface dpm_result_if;
	logic                           valid;
	logic                           ready;
	logic [dpm_pkg::DUTY_W-1:0]     duty;
	logic                           direction;
	logic [dpm_pkg::MODE_W-1:0]     bridge_mode;
	logic [dpm_pkg::STAT_W-1:0]     status;

	modport source (
		output valid, duty, direction, bridge_mode, status,
		input  ready
	);
	modport sink (
		input  valid, duty, direction, bridge_mode, status,
		output ready
	);
endinterface

`default_nettype wire

### sv/dpm_div.sv
// ----------------------------------------------------------------------------
// dpm_div
// Restoring serial divider, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [15:0]        dividend,
	input  wire logic [15:0]        divisor,
	input  wire logic               negate,
	output logic                    busy,
	output logic signed [16:0]      quotient
);

	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [15:0] dvd_q;
	logic [15:0] dsr_q;
	logic        neg_q;

	logic [16:0] rem_shift;
	logic        fits;

	assign rem_shift = {rem_q[15:0], dvd_q[15]};
	assign fits      = rem_shift >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			neg_q <= negate;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? rem_shift - {1'b0, dsr_q} : rem_shift;
			dvd_q <= {dvd_q[14:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

`default_nettype wire

### sv/distance_pid_move_controller_top.sv
// sequence: an item is taken in ST_IDLE; start items and samples that need no control
// step go from ST_EVAL to ST_EMIT, while a full control step runs through ST_EVAL,
// ST_MULP, ST_MULD, ST_DIVW (waiting on the 16-step serial divider for the integral
// term), ST_SUM, ST_FIN and ST_EMIT; the next item is taken in the cycle the result
// word turns valid, and a result word left waiting stalls the sequencer
// reset: arst_n sets the config and move registers to defaults and the move to idle
// ----------------------------------------------------------------------------
// distance_pid_move_controller_top
// Distance move controller with a PID step on one shared multiplier and a
// serial divider under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_pid_move_controller_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [dpm_pkg::CIDX_W-1:0]            cfg_index,
	input  wire logic [dpm_pkg::CDATA_W-1:0]           cfg_data,
	dpm_item_if.sink                                   item,
	dpm_result_if.source                               result
);

	// configuration registers
	logic [7:0]  prop_gain_q;
	logic [15:0] int_div_q;
	logic [7:0]  kd_slow_q, kd_medium_q, kd_fast_q;
	logic [15:0] lim_slow_q, lim_medium_q, lim_fast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= 8'd5;
			int_div_q    <= 16'd14000;
			kd_slow_q    <= 8'd10;
			kd_medium_q  <= 8'd23;
			kd_fast_q    <= 8'd23;
			lim_slow_q   <= 16'd1499;
			lim_medium_q <= 16'd3999;
			lim_fast_q   <= 16'd7999;
		end else if (cfg_we) begin
			case (cfg_index)
				dpm_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data[7:0];
				dpm_pkg::REG_INT_DIV:    int_div_q    <= cfg_data;
				dpm_pkg::REG_KD_SLOW:    kd_slow_q    <= cfg_data[7:0];
				dpm_pkg::REG_KD_MEDIUM:  kd_medium_q  <= cfg_data[7:0];
				dpm_pkg::REG_KD_FAST:    kd_fast_q    <= cfg_data[7:0];
				dpm_pkg::REG_LIM_SLOW:   lim_slow_q   <= cfg_data;
				dpm_pkg::REG_LIM_MEDIUM: lim_medium_q <= cfg_data;
				dpm_pkg::REG_LIM_FAST:   lim_fast_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and move state
	dpm_pkg::seq_state_t state_q;
	dpm_pkg::phase_t     phase_q;
	logic signed [15:0]  target_q;
	logic [1:0]          speed_q;
	logic signed [31:0]  integral_q;
	logic signed [15:0]  last_err_q;
	logic [7:0]          step_q;
	logic                last_dir_q;

	// latched item
	logic                kind_q;
	logic signed [10:0]  dist_q;
	logic [1:0]          speed_in_q;
	logic [15:0]         range_q;
	logic signed [17:0]  enc_sum_q;

	// step datapath
	logic signed [15:0]  err_q;
	logic signed [15:0]  derr_q;
	logic signed [31:0]  acc_q;
	logic signed [31:0]  drive_q;
	dpm_pkg::result_t    res_q;

	// output register
	logic                out_valid_q;
	dpm_pkg::result_t    out_q;

	logic in_fire;
	assign item.ready = state_q == dpm_pkg::ST_IDLE;
	assign in_fire    = item.valid && item.ready;

	// offset counts, each wrapped to 16 bits, summed at acceptance
	logic [15:0] ca, cb, cc, cd;
	assign ca = item.encoder_a + dpm_pkg::OFFSET_A;
	assign cb = item.encoder_b - dpm_pkg::OFFSET_B;
	assign cc = item.encoder_c + dpm_pkg::OFFSET_C;
	assign cd = item.encoder_d - dpm_pkg::OFFSET_D;

	logic signed [17:0] enc_sum;
	assign enc_sum = 18'($signed(ca)) + 18'($signed(cb)) + 18'($signed(cc))
		+ 18'($signed(cd));

	// average truncated toward zero, error and its change
	logic signed [17:0] sum_adj;
	logic signed [15:0] avg, err, derr;
	assign sum_adj = enc_sum_q + (enc_sum_q[17] ? 18'sd3 : 18'sd0);
	assign avg     = 16'(sum_adj >>> 2);
	assign err     = target_q - avg;
	assign derr    = err - last_err_q;

	logic signed [15:0] target_new;
	assign target_new = 16'(16'($signed(dist_q)) * 16'(dpm_pkg::COUNTS_PER_CM));

	// speed class selects gain and limit
	logic [7:0]  kd_sel;
	logic [15:0] lim_sel;
	always_comb begin
		case (speed_q)
			2'd2: begin
				kd_sel  = kd_medium_q;
				lim_sel = lim_medium_q;
			end
			2'd3: begin
				kd_sel  = kd_fast_q;
				lim_sel = lim_fast_q;
			end
			default: begin
				kd_sel  = kd_slow_q;
				lim_sel = lim_slow_q;
			end
		endcase
	end

	// shared multiplier
	logic signed [15:0] mul_a;
	logic [7:0]         mul_b;
	logic signed [24:0] prod;
	assign mul_a = (state_q == dpm_pkg::ST_MULP) ? err_q : derr_q;
	assign mul_b = (state_q == dpm_pkg::ST_MULP) ? prop_gain_q : kd_sel;
	assign prod  = 25'(mul_a) * 25'($signed({1'b0, mul_b}));

	// divider for the integral term
	logic               div_start, div_busy;
	logic signed [16:0] div_quo;
	logic [15:0]        err_mag;
	assign err_mag = err[15] ? 16'(-err) : err;

	logic run_path, obstacle, timed_out, idle_sample, wait_zero;
	assign idle_sample = phase_q == dpm_pkg::PH_IDLE;
	assign wait_zero   = phase_q == dpm_pkg::PH_WAIT && range_q == '0;
	assign obstacle    = {1'b0, range_q} < 17'(dpm_pkg::OBSTACLE_RANGE_MM);
	assign timed_out   = step_q > 8'(dpm_pkg::TIMEOUT_STEPS);
	assign run_path    = kind_q == dpm_pkg::KIND_SAMPLE && !idle_sample && !wait_zero
		&& !obstacle && !timed_out;
	assign div_start   = state_q == dpm_pkg::ST_EVAL && run_path && int_div_q != '0;

	dpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (err_mag),
		.divisor  (int_div_q),
		.negate   (err[15]),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// magnitude, clamp and direction
	logic        drive_neg, drive_zero, dir_new;
	logic [31:0] drive_mag;
	logic [15:0] duty_clamped;
	logic        arrived;
	assign drive_neg    = drive_q[31];
	assign drive_zero   = drive_q == '0;
	assign drive_mag    = drive_neg ? 32'(-drive_q) : 32'(drive_q);
	assign duty_clamped = (drive_mag > {16'd0, lim_sel}) ? lim_sel : drive_mag[15:0];
	assign dir_new      = drive_neg ? 1'b1 : (drive_zero ? last_dir_q : 1'b0);
	assign arrived      = err_q < $signed(16'(dpm_pkg::ARRIVE_TOLERANCE))
		&& err_q > -$signed(16'(dpm_pkg::ARRIVE_TOLERANCE)) && derr_q == '0;

	logic out_free;
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dpm_pkg::ST_IDLE;
			phase_q    <= dpm_pkg::PH_IDLE;
			target_q   <= '0;
			speed_q    <= 2'd1;
			integral_q <= '0;
			last_err_q <= '0;
			step_q     <= '0;
			last_dir_q <= 1'b0;
		end else begin
			case (state_q)
				dpm_pkg::ST_IDLE: begin
					if (in_fire) state_q <= dpm_pkg::ST_EVAL;
				end
				dpm_pkg::ST_EVAL: begin
					if (kind_q == dpm_pkg::KIND_START) begin
						target_q   <= target_new;
						speed_q    <= (speed_in_q == '0) ? 2'd1 : speed_in_q;
						step_q     <= '0;
						last_err_q <= '0;
						phase_q    <= dpm_pkg::PH_WAIT;
						state_q    <= dpm_pkg::ST_EMIT;
					end else if (idle_sample || wait_zero) begin
						state_q <= dpm_pkg::ST_EMIT;
					end else if (obstacle || timed_out) begin
						phase_q <= dpm_pkg::PH_IDLE;
						state_q <= dpm_pkg::ST_EMIT;
					end else begin
						phase_q    <= dpm_pkg::PH_RUN;
						last_err_q <= err;
						state_q    <= dpm_pkg::ST_MULP;
					end
				end
				dpm_pkg::ST_MULP: state_q <= dpm_pkg::ST_MULD;
				dpm_pkg::ST_MULD: state_q <= dpm_pkg::ST_DIVW;
				dpm_pkg::ST_DIVW: begin
					if (int_div_q == '0) begin
						state_q <= dpm_pkg::ST_SUM;
					end else if (!div_busy) begin
						integral_q <= integral_q + 32'(div_quo);
						state_q    <= dpm_pkg::ST_SUM;
					end
				end
				dpm_pkg::ST_SUM: state_q <= dpm_pkg::ST_FIN;
				dpm_pkg::ST_FIN: begin
					last_dir_q <= dir_new;
					if (arrived) begin
						phase_q <= dpm_pkg::PH_IDLE;
					end else if (step_q != 8'hFF) begin
						step_q <= step_q + 8'd1;
					end
					state_q <= dpm_pkg::ST_EMIT;
				end
				dpm_pkg::ST_EMIT: begin
					if (out_free) state_q <= dpm_pkg::ST_IDLE;
				end
				default: state_q <= dpm_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q     <= item.kind;
			dist_q     <= item.move_distance;
			speed_in_q <= item.speed_class;
			range_q    <= item.range_reading;
			enc_sum_q  <= enc_sum;
		end
		case (state_q)
			dpm_pkg::ST_EVAL: begin
				err_q           <= err;
				derr_q          <= derr;
				res_q.direction <= last_dir_q;
				if (kind_q == dpm_pkg::KIND_START || wait_zero) begin
					res_q.duty        <= '0;
					res_q.bridge_mode <= dpm_pkg::MODE_COAST;
					res_q.status      <= dpm_pkg::STAT_WAITING;
				end else if (idle_sample) begin
					res_q.duty        <= '0;
					res_q.bridge_mode <= dpm_pkg::MODE_COAST;
					res_q.status      <= dpm_pkg::STAT_IDLE;
				end else if (obstacle) begin
					res_q.duty        <= dpm_pkg::BRAKE_DUTY;
					res_q.bridge_mode <= dpm_pkg::MODE_BRAKE;
					res_q.status      <= dpm_pkg::STAT_OBSTACLE;
				end else begin
					res_q.duty        <= '0;
					res_q.bridge_mode <= dpm_pkg::MODE_COAST;
					res_q.status      <= dpm_pkg::STAT_TIMEOUT;
				end
			end
			dpm_pkg::ST_MULP: acc_q <= 32'(prod);
			dpm_pkg::ST_MULD: acc_q <= acc_q + 32'(prod);
			dpm_pkg::ST_SUM:  drive_q <= acc_q + integral_q;
			dpm_pkg::ST_FIN: begin
				res_q.direction <= dir_new;
				if (arrived) begin
					res_q.duty        <= '0;
					res_q.bridge_mode <= dpm_pkg::MODE_COAST;
					res_q.status      <= dpm_pkg::STAT_REACHED;
				end else begin
					res_q.duty        <= duty_clamped;
					res_q.bridge_mode <= dpm_pkg::MODE_DRIVE;
					res_q.status      <= dpm_pkg::STAT_RUNNING;
				end
			end
			default: ;
		endcase
		if (state_q == dpm_pkg::ST_EMIT && out_free) out_q <= res_q;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dpm_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.duty        = out_q.duty;
	assign result.direction   = out_q.direction;
	assign result.bridge_mode = out_q.bridge_mode;
	assign result.status      = out_q.status;

endmodule

`default_nettype wire

### tb/distance_pid_move_controller_top_test.sv
// ----------------------------------------------------------------------------
// distance_pid_move_controller_top_test
// Self-checking bench for the distance move controller. A model of the PID
// step tracks moves, waiting, obstacle, timeout and arrival, and checks every
// result word. Directed moves run first, then random moves under several gain
// settings. Both channels get random gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_pid_move_controller_top_test;

	import dpm_pkg::*;

	typedef struct {
		logic                     kind;
		logic signed [DIST_W-1:0] move_distance;
		logic [SPEED_W-1:0]       speed_class;
		logic [ENC_W-1:0]         encoder_a;
		logic [ENC_W-1:0]         encoder_b;
		logic [ENC_W-1:0]         encoder_c;
		logic [ENC_W-1:0]         encoder_d;
		logic [RANGE_W-1:0]       range_reading;
	} move_item_t;

	class move_checker;
		logic [7:0]         prop_gain;
		logic [15:0]        int_div;
		logic [7:0]         kd[3];
		logic [15:0]        lim[3];
		logic signed [15:0] target;
		logic [1:0]         speed;
		logic [31:0]        integ;
		logic signed [15:0] prev_err;
		logic [7:0]         steps;
		phase_t             phase;
		logic               heading;
		result_t            due_words[$];
		int                 faults;

		function new();
			prop_gain = 8'd5;
			int_div   = 16'd14000;
			kd        = '{8'd10, 8'd23, 8'd23};
			lim       = '{16'd1499, 16'd3999, 16'd7999};
			target    = '0;
			speed     = 2'd1;
			integ     = '0;
			prev_err  = '0;
			steps     = '0;
			phase     = PH_IDLE;
			heading   = 1'b0;
			faults    = 0;
		endfunction

		function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] v);
			case (idx)
				REG_PROP_GAIN:  prop_gain = v[7:0];
				REG_INT_DIV:    int_div = v;
				REG_KD_SLOW:    kd[0] = v[7:0];
				REG_KD_MEDIUM:  kd[1] = v[7:0];
				REG_KD_FAST:    kd[2] = v[7:0];
				REG_LIM_SLOW:   lim[0] = v;
				REG_LIM_MEDIUM: lim[1] = v;
				REG_LIM_FAST:   lim[2] = v;
				default: ;
			endcase
		endfunction

		function result_t out_word(logic [15:0] duty, logic dir, bridge_mode_t mode,
				status_t st);
			result_t r;
			r.duty        = duty;
			r.direction   = dir;
			r.bridge_mode = mode;
			r.status      = st;
			return r;
		endfunction

		function result_t pid_step(move_item_t w);
			logic signed [15:0] ca, cb, cc, cd, err, derr;
			int                 avg, si;
			logic [31:0]        drive, mag;
			if (w.kind == KIND_START) begin
				target   = 16'(int'(w.move_distance) * int'(COUNTS_PER_CM));
				speed    = (w.speed_class == 2'd0) ? 2'd1 : w.speed_class;
				steps    = '0;
				prev_err = '0;
				phase    = PH_WAIT;
				return out_word(16'd0, heading, MODE_COAST, STAT_WAITING);
			end
			if (phase == PH_IDLE)
				return out_word(16'd0, heading, MODE_COAST, STAT_IDLE);
			if (phase == PH_WAIT) begin
				if (w.range_reading == '0)
					return out_word(16'd0, heading, MODE_COAST, STAT_WAITING);
				phase = PH_RUN;
			end
			if (int'(w.range_reading) / 10 < int'(OBSTACLE_RANGE_TENTHS)) begin
				phase = PH_IDLE;
				return out_word(BRAKE_DUTY, heading, MODE_BRAKE, STAT_OBSTACLE);
			end
			if (steps > TIMEOUT_STEPS) begin
				phase = PH_IDLE;
				return out_word(16'd0, heading, MODE_COAST, STAT_TIMEOUT);
			end
			ca   = w.encoder_a + OFFSET_A;
			cb   = w.encoder_b - OFFSET_B;
			cc   = w.encoder_c + OFFSET_C;
			cd   = w.encoder_d - OFFSET_D;
			avg  = (int'(ca) + int'(cb) + int'(cc) + int'(cd)) / 4;
			err  = 16'(int'(target) - avg);
			derr = 16'(int'(err) - int'(prev_err));
			si   = (speed == 2'd0) ? 0 : int'(speed) - 1;
			if (si > 2)
				si = 2;
			if (int_div != '0)
				integ = integ + 32'(int'(err) / int'({16'b0, int_div}));
			drive = 32'(int'(err) * int'({24'b0, prop_gain}))
				+ 32'(int'(derr) * int'({24'b0, kd[si]})) + integ;
			// zero drive keeps the old direction
			if ($signed(drive) < 0)
				heading = 1'b1;
			else if (drive != '0)
				heading = 1'b0;
			mag = drive[31] ? -drive : drive;
			if (mag > {16'b0, lim[si]})
				mag = {16'b0, lim[si]};
			prev_err = err;
			if (int'(err) < int'(ARRIVE_TOLERANCE) && int'(err) > -int'(ARRIVE_TOLERANCE)
					&& derr == '0) begin
				phase = PH_IDLE;
				return out_word(16'd0, heading, MODE_COAST, STAT_REACHED);
			end
			if (steps != 8'hFF)
				steps++;
			return out_word(mag[15:0], heading, MODE_DRIVE, STAT_RUNNING);
		endfunction

		function void take_item(move_item_t w);
			due_words.push_back(pid_step(w));
		endfunction

		function void match_result(logic [15:0] duty, logic dir, logic [1:0] mode,
				logic [2:0] st);
			result_t want;
			if (due_words.size() == 0) begin
				if (faults < 10)
					$display("unexpected word: duty=%0d dir=%0b mode=%0d stat=%0d",
						duty, dir, mode, st);
				faults++;
				return;
			end
			want = due_words.pop_front();
			if (want.duty !== duty || want.direction !== dir || want.bridge_mode !== mode
					|| want.status !== st) begin
				if (faults < 10)
					$display("mismatch: want duty=%0d dir=%0b mode=%0d stat=%0d, got duty=%0d dir=%0b mode=%0d stat=%0d",
						want.duty, want.direction, want.bridge_mode, want.status,
						duty, dir, mode, st);
				faults++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CDATA_W-1:0]  cfg_data;

	dpm_item_if   item_ch();
	dpm_result_if result_ch();

	distance_pid_move_controller_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	move_checker chk;
	int          tx_calm = 0;
	int          rx_calm = 0;
	int          sent = 0;

	always #2 clk = ~clk;

	// random gap per word, with occasional stretches of none
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 30) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic int spread(int jit);
		return int'($urandom_range(0, 2 * jit)) - jit;
	endfunction

	function automatic logic [15:0] run_range();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(300, 400));
		return 16'($urandom_range(300, 65535));
	endfunction

	function automatic logic [15:0] reg_value(int which, int bits);
		logic [15:0] top;
		top = 16'((1 << bits) - 1);
		case (which)
			1: return top;
			2: return 16'd0;
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'd0;
					1: return top;
					default: return 16'($urandom_range(0, int'(top)));
				endcase
			end
		endcase
	endfunction

	task automatic send_word(move_item_t w);
		int gap;
		gap = pick_wait(tx_calm);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.kind          <= w.kind;
		item_ch.move_distance <= w.move_distance;
		item_ch.speed_class   <= w.speed_class;
		item_ch.encoder_a     <= w.encoder_a;
		item_ch.encoder_b     <= w.encoder_b;
		item_ch.encoder_c     <= w.encoder_c;
		item_ch.encoder_d     <= w.encoder_d;
		item_ch.range_reading <= w.range_reading;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		chk.take_item(w);
		sent++;
	endtask

	task automatic send_start(int cm, int sp);
		move_item_t w;
		w.kind          = KIND_START;
		w.move_distance = 11'(cm);
		w.speed_class   = 2'(sp);
		w.encoder_a     = 16'($urandom);
		w.encoder_b     = 16'($urandom);
		w.encoder_c     = 16'($urandom);
		w.encoder_d     = 16'($urandom);
		w.range_reading = 16'($urandom);
		send_word(w);
	endtask

	// four wheels placed so the offset counts average to position p
	task automatic send_at(int p, int jit, logic [15:0] rng);
		move_item_t w;
		w.kind          = KIND_SAMPLE;
		w.move_distance = 11'($urandom);
		w.speed_class   = 2'($urandom);
		w.encoder_a     = 16'(p - int'(OFFSET_A) + spread(jit));
		w.encoder_b     = 16'(p + int'(OFFSET_B) + spread(jit));
		w.encoder_c     = 16'(p - int'(OFFSET_C) + spread(jit));
		w.encoder_d     = 16'(p + int'(OFFSET_D) + spread(jit));
		w.range_reading = rng;
		send_word(w);
	endtask

	task automatic send_raw(logic [15:0] e, logic [15:0] rng);
		move_item_t w;
		w.kind          = KIND_SAMPLE;
		w.move_distance = 11'($urandom);
		w.speed_class   = 2'($urandom);
		w.encoder_a     = e;
		w.encoder_b     = e;
		w.encoder_c     = e;
		w.encoder_d     = e;
		w.range_reading = rng;
		send_word(w);
	endtask

	task automatic send_noise();
		move_item_t w;
		w.kind          = 1'($urandom);
		w.move_distance = 11'($urandom);
		w.speed_class   = 2'($urandom);
		w.encoder_a     = 16'($urandom);
		w.encoder_b     = 16'($urandom);
		w.encoder_c     = 16'($urandom);
		w.encoder_d     = 16'($urandom);
		w.range_reading = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
		send_word(w);
	endtask

	// hold input until every pending word is back
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk.due_words.size() != 0) @(posedge clk);
	endtask

	task automatic put_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		chk.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_settings(int which);
		put_reg(REG_PROP_GAIN, reg_value(which, 8));
		put_reg(REG_INT_DIV, (which == 3) ? 16'd1 : reg_value(which, 16));
		put_reg(REG_KD_SLOW, reg_value(which, 8));
		put_reg(REG_KD_MEDIUM, reg_value(which, 8));
		put_reg(REG_KD_FAST, reg_value(which, 8));
		put_reg(REG_LIM_SLOW, reg_value(which, 16));
		put_reg(REG_LIM_MEDIUM, reg_value(which, 16));
		put_reg(REG_LIM_FAST, reg_value(which, 16));
		cfg_we <= 1'b0;
	endtask

	task automatic directed_moves();
		logic signed [15:0] aim;
		send_at(0, 0, 16'd1000);
		// small errors chosen so the drive cancels to zero on the second step
		send_start(0, 1);
		send_at(0, 0, 16'd0);
		send_at(3, 0, 16'd1000);
		send_at(2, 0, 16'd1000);
		send_at(2, 0, 16'd1000);
		send_at(2, 0, 16'd1000);
		send_start(682, 3);
		send_at(0, 0, 16'd300);
		send_raw(16'hFFFF, 16'hFFFF);
		send_raw(16'h0000, 16'd299);
		send_start(-682, 2);
		send_raw(16'h8000, 16'd1);
		send_start(-1024, 0);
		send_raw(16'h7FFF, 16'hFFFF);
		send_at(0, 0, 16'd5000);
		// target wraps; landing on it right away arrives at once
		send_start(1023, 2);
		aim = 16'(1023 * int'(COUNTS_PER_CM));
		send_at(aim, 0, 16'd500);
		send_start(1, 1);
		send_at(148, 0, 16'd1000);
		send_at(48, 0, 16'd1000);
	endtask

	task automatic run_move();
		int                 style, span, sp, p, off;
		logic signed [15:0] aim;
		style = $urandom_range(0, 19);
		if (style < 2) begin
			repeat ($urandom_range(1, 6)) send_noise();
			return;
		end
		if ($urandom_range(0, 9) == 0)
			span = int'($urandom_range(0, 2047)) - 1024;
		else
			span = int'($urandom_range(0, 1364)) - 682;
		sp = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		send_start(span, sp);
		aim = 16'(span * int'(COUNTS_PER_CM));
		repeat ($urandom_range(0, 3)) send_at(int'($urandom_range(0, 2000)), 50, 16'd0);
		p = int'($urandom_range(0, 200)) - 100;
		if (style < 5) begin
			// stay well off target until the step count runs out
			repeat (int'(TIMEOUT_STEPS) + 3) begin
				off = 200 + int'($urandom_range(0, 3000));
				if ($urandom_range(0, 1) == 0)
					off = -off;
				send_at(int'(aim) + off, 0, run_range());
			end
			return;
		end
		repeat ($urandom_range(1, 25)) begin
			p = p + (int'(aim) - p) / 3 + spread(40);
			send_at(p, 4, run_range());
		end
		if (style < 10)
			send_at(p, 4, 16'($urandom_range(1, 299)));
		else begin
			p = int'(aim) + spread(60);
			send_at(p, 0, run_range());
			send_at(p, 0, run_range());
		end
		repeat ($urandom_range(0, 2)) send_at(p, 4, run_range());
	endtask

	initial begin : result_side
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = pick_wait(rx_calm);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			chk.match_result(result_ch.duty, result_ch.direction, result_ch.bridge_mode,
				result_ch.status);
		end
	end

	initial begin
		chk = new();
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		item_ch.valid         <= 1'b0;
		item_ch.kind          <= KIND_START;
		item_ch.move_distance <= '0;
		item_ch.speed_class   <= '0;
		item_ch.encoder_a     <= '0;
		item_ch.encoder_b     <= '0;
		item_ch.encoder_c     <= '0;
		item_ch.encoder_d     <= '0;
		item_ch.range_reading <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_moves();
		// setting 1 is all at the top, 2 all zero, 3 unit divisor, then random
		for (int ph = 1; ph <= 7; ph++) begin
			settle();
			load_settings(ph);
			while (sent < 20 + ph * 270) begin
				if ($urandom_range(0, 40) == 0)
					settle();
				run_move();
			end
		end
		settle();
		repeat (40) @(posedge clk);
		if (chk.faults == 0 && chk.due_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
sv/dpm_pkg.sv
sv/dpm_if.sv
sv/dpm_div.sv
sv/distance_pid_move_controller_top.sv
tb/distance_pid_move_controller_top_test.sv
